>>> rtl/core/idwa_pkg.sv
// package for the inverse distance weight accumulator
`default_nettype none
package idwa_pkg;
  localparam int unsigned GridPoints = 4096;
  localparam int unsigned IdxW = $clog2(GridPoints);
  localparam int unsigned CoordW = 20;
  localparam int unsigned ValW = 24;
  localparam int unsigned SumW = 48;
  localparam int unsigned WtW = 47;
  localparam int unsigned D2W = 43;
  localparam int unsigned DW = 22;
  localparam int unsigned WW = 25;
  localparam int unsigned QW = 25;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SQRT, ST_DIV, ST_MUL, ST_READ, ST_SUM, ST_OUT
  } state_e;
endpackage
`default_nettype wire

>>> rtl/core/inverse_distance_weight_accumulate.sv
// inverse distance weight accumulator top level
//
// Each request pairs one sample (three Q8.16 values, Q12.8 position) with a
// grid point (Q12.8 position, store index). The block forms the squared
// distance, its integer square root, the Q9.16 weight 1/d, and adds
// value*weight to three sums and the weight to a fourth at the index.
// One result with the updated sums follows each request; zero_distance_o
// flags a coincident pair, whose sums come back unchanged.
// Steps in order: squaring, a digit-by-digit square root, a restoring
// divider, a memory read, then a sum and write-back step. A coincident
// pair skips the root and the divider. One request is worked on at a
// time; the next one is taken only once the last result has left the
// output register.
// After reset a clearing pass writes zero into all 4096 entries, one a
// cycle; no request is taken during the clearing pass.
// The result sits in an output register; while the receiver stalls the
// register holds and the next request waits.
`default_nettype none
module inverse_distance_weight_accumulate (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire signed [idwa_pkg::ValW-1:0]       sample_value_a_i,
  input  wire signed [idwa_pkg::ValW-1:0]       sample_value_b_i,
  input  wire signed [idwa_pkg::ValW-1:0]       sample_value_c_i,
  input  wire        [idwa_pkg::CoordW-1:0]     sample_x_i,
  input  wire        [idwa_pkg::CoordW-1:0]     sample_y_i,
  input  wire        [idwa_pkg::CoordW-1:0]     sample_z_i,
  input  wire        [idwa_pkg::CoordW-1:0]     point_x_i,
  input  wire        [idwa_pkg::CoordW-1:0]     point_y_i,
  input  wire        [idwa_pkg::CoordW-1:0]     point_z_i,
  input  wire        [idwa_pkg::IdxW-1:0]       grid_index_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [idwa_pkg::SumW-1:0]      sum_a_o,
  output logic signed [idwa_pkg::SumW-1:0]      sum_b_o,
  output logic signed [idwa_pkg::SumW-1:0]      sum_c_o,
  output logic        [idwa_pkg::WtW-1:0]       weight_total_o,
  output logic                                  zero_distance_o
);
  import idwa_pkg::*;

  localparam logic signed [SumW+1:0] SMax = {3'b000, {(SumW-1){1'b1}}};
  localparam logic signed [SumW+1:0] SMin = {3'b111, {(SumW-1){1'b0}}};

  // accumulator memories
  logic [SumW-1:0] mem_a [GridPoints];
  logic [SumW-1:0] mem_b [GridPoints];
  logic [SumW-1:0] mem_c [GridPoints];
  logic [WtW-1:0]  mem_w [GridPoints];
  logic [SumW-1:0] rd_a_q, rd_b_q, rd_c_q;
  logic [WtW-1:0]  rd_w_q;

  state_e state_q, state_d;
  logic [IdxW:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q;
  logic signed [ValW-1:0] va_q, vb_q, vc_q;
  logic signed [CoordW:0] dx_q, dy_q, dz_q;
  logic [D2W-1:0] d2_q;
  // root state
  logic [D2W-1:0] rv_q;
  logic [D2W:0] rr_q, rb_q;
  // divider state
  logic [WW-1:0] rem_q;
  logic [QW-1:0] quo_q;
  logic [DW-1:0] dd_q;
  logic signed [SumW+1:0] ta_q, tb_q, tc_q;
  logic zero_q;

  logic we;
  logic [IdxW-1:0] wa;
  logic [SumW-1:0] wd_a, wd_b, wd_c;
  logic [WtW-1:0] wd_w;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_a[wa] <= wd_a;
      mem_b[wa] <= wd_b;
      mem_c[wa] <= wd_c;
      mem_w[wa] <= wd_w;
    end
    rd_a_q <= mem_a[idx_q];
    rd_b_q <= mem_b[idx_q];
    rd_c_q <= mem_c[idx_q];
    rd_w_q <= mem_w[idx_q];
  end

  // saturating sums
  logic signed [SumW+1:0] na, nb, nc;
  logic [WtW:0] nw;
  logic [SumW-1:0] sa, sb, sc;
  logic [WtW-1:0] sw;
  always_comb begin
    na = $signed({{2{rd_a_q[SumW-1]}}, rd_a_q}) + ta_q;
    nb = $signed({{2{rd_b_q[SumW-1]}}, rd_b_q}) + tb_q;
    nc = $signed({{2{rd_c_q[SumW-1]}}, rd_c_q}) + tc_q;
    nw = {1'b0, rd_w_q} + {{(WtW+1-QW){1'b0}}, quo_q};
    sa = (na > SMax) ? SMax[SumW-1:0] : (na < SMin) ? SMin[SumW-1:0] : na[SumW-1:0];
    sb = (nb > SMax) ? SMax[SumW-1:0] : (nb < SMin) ? SMin[SumW-1:0] : nb[SumW-1:0];
    sc = (nc > SMax) ? SMax[SumW-1:0] : (nc < SMin) ? SMin[SumW-1:0] : nc[SumW-1:0];
    sw = nw[WtW] ? {WtW{1'b1}} : nw[WtW-1:0];
  end

  // root and divider step logic
  logic [D2W:0] rtry;
  logic [WW:0] dtry;
  logic [WW:0] dsh;
  always_comb begin
    rtry = rr_q + rb_q;
    dsh  = {rem_q, 1'b0};
    dtry = dsh - {{(WW+1-DW){1'b0}}, dd_q};
  end

  // full squared distance in the last squaring cycle
  logic [D2W-1:0] d2_last;
  assign d2_last = d2_q + D2W'(dz_q * dz_q);

  // product stage
  logic signed [ValW+WW:0] pa, pb, pc;
  logic signed [ValW+WW:0] wsig;
  always_comb begin
    wsig = $signed({{(ValW+1){1'b0}}, quo_q});
    pa = $signed({{(WW+1){va_q[ValW-1]}}, va_q}) * wsig + 32768;
    pb = $signed({{(WW+1){vb_q[ValW-1]}}, vb_q}) * wsig + 32768;
    pc = $signed({{(WW+1){vc_q[ValW-1]}}, vc_q}) * wsig + 32768;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    in_stall_o = 1'b1;
    we = 1'b0;
    wa = idx_q;
    wd_a = sa; wd_b = sb; wd_c = sc; wd_w = sw;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wa = cnt_q[IdxW-1:0];
        wd_a = '0; wd_b = '0; wd_c = '0; wd_w = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[IdxW-1:0] == {IdxW{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = out_valid_o;
        if (in_valid_i && !out_valid_o) begin
          state_d = ST_MUL;
          cnt_d = '0;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2) state_d = (d2_last == '0) ? ST_READ : ST_SQRT;
      end
      ST_SQRT: if (rb_q == '0) state_d = ST_DIV;
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == QW - 1) state_d = ST_READ;
      end
      ST_READ: state_d = ST_SUM;
      ST_SUM: begin
        we = !zero_q;
        state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= state_d != state_q && state_q != ST_IDLE ? '0 : cnt_d;
      if (state_q == ST_SUM) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        va_q <= sample_value_a_i; vb_q <= sample_value_b_i; vc_q <= sample_value_c_i;
        dx_q <= $signed({1'b0, sample_x_i}) - $signed({1'b0, point_x_i});
        dy_q <= $signed({1'b0, sample_y_i}) - $signed({1'b0, point_y_i});
        dz_q <= $signed({1'b0, sample_z_i}) - $signed({1'b0, point_z_i});
        idx_q <= grid_index_i;
        d2_q <= '0;
      end
      ST_MUL: begin
        // one square a cycle
        case (cnt_q[1:0])
          2'd0: d2_q <= d2_q + D2W'(dx_q * dx_q);
          2'd1: d2_q <= d2_q + D2W'(dy_q * dy_q);
          default: begin
            d2_q <= d2_last;
            zero_q <= d2_last == '0;
            rv_q <= d2_last;
            rr_q <= '0;
            rb_q <= (D2W+1)'(1) << 42;
          end
        endcase
      end
      ST_SQRT: begin
        if (rb_q != '0) begin
          if ({1'b0, rv_q} >= rtry) begin
            rv_q <= rv_q - rtry[D2W-1:0];
            rr_q <= (rr_q >> 1) + rb_q;
          end else begin
            rr_q <= rr_q >> 1;
          end
          rb_q <= rb_q >> 2;
        end else begin
          dd_q <= rr_q[DW-1:0];
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        // dividend 2^24, one quotient bit a cycle, msb first
        if (cnt_q == 0) begin
          // bit 24 of dividend enters here
          if ({{(WW){1'b0}}, 1'b1} >= {{(WW+1-DW){1'b0}}, dd_q}) begin
            rem_q <= WW'({{(WW){1'b0}}, 1'b1} - {{(WW+1-DW){1'b0}}, dd_q});
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= WW'(1);
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
        end else if (!dtry[WW]) begin
          rem_q <= dtry[WW-1:0];
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= dsh[WW-1:0];
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      ST_READ: begin
        // terms floored to q.16 after the half offset
        if (zero_q) begin
          quo_q <= '0;
          ta_q <= '0;
          tb_q <= '0;
          tc_q <= '0;
        end else begin
          ta_q <= pa >>> 16;
          tb_q <= pb >>> 16;
          tc_q <= pc >>> 16;
        end
      end
      ST_SUM: begin
        sum_a_o <= sa; sum_b_o <= sb; sum_c_o <= sc; weight_total_o <= sw;
        zero_distance_o <= zero_q;
      end
      default: ;
    endcase
  end

  // checks
  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_o) else $error("result during clear");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sum_a_o))
    else $error("stalled result lost");
  a_zero_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM && zero_q |-> !we) else $error("write on zero distance");
endmodule
`default_nettype wire
